/* sv/tte_pkg.sv */
// tte_pkg: shared widths, constants, result codes and the comparator result struct
// for the tap tempo estimator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tte_pkg;

	localparam int TIME_W     = 32;
	localparam int CFG_W      = 16;
	localparam int INTERVAL_W = 16;
	localparam int BPM_W      = 26;
	localparam int STATUS_W   = 3;
	localparam int COUNT_W    = 3;

	// ring of intervals, depth kept a power of two so the mean is a shift
	localparam int RING_LOG2  = 2;
	localparam int RING_DEPTH = 1 << RING_LOG2;
	localparam int SUM_W      = INTERVAL_W + RING_LOG2;

	localparam int CMP_CNT_W  = $clog2(TIME_W);
	localparam int DIV_CNT_W  = $clog2(BPM_W);

	localparam logic [BPM_W-1:0] BPM_NUMERATOR = BPM_W'(60000000);

	localparam logic [CFG_W-1:0] DEBOUNCE_RESET = CFG_W'(100);
	localparam logic [CFG_W-1:0] TIMEOUT_RESET  = CFG_W'(2000);

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_BOUNCE  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_RESTART = 3'd1;
	localparam logic [STATUS_W-1:0] ST_STORED  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_TEMPO   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_CANCEL  = 3'd4;

	localparam logic REQ_TAP    = 1'b0;
	localparam logic REQ_CANCEL = 1'b1;

	typedef struct packed {
		logic                  bounce;
		logic                  restart;
		logic [INTERVAL_W-1:0] delay;
	} cmp_res_t;

endpackage
`default_nettype wire

/* sv/tap_tempo_estimator.sv */
// tap_tempo_estimator: top level with tap state, interval ring, control sequencer
// and result register. Depends on tte_pkg, tte_serial_cmp and tte_divider.
//
// Usage:
//  - input channel in_valid/in_ready carries req_type (tap or cancel) and now_ms
//  - output channel out_valid/out_ready carries tap_status, bpm_milli, tap_count
//    and ring_position, one result per request, in request order
//  - cfg_we/cfg_index/cfg_data writes debounce_ms (index 0) or timeout_ms (index 1);
//    write only while no request is in flight
//  - one request at a time; in_ready returns the cycle after the result register loads
//  - a cancel goes from idle straight to the done state, then loads the result register
//  - a tap runs a bit-serial subtract and compare over the 32 timestamp bits;
//    a tap that yields a tempo then runs the restoring divider, one quotient bit a cycle
//  - reset clears all tap state, loads debounce 100 ms and timeout 2000 ms and
//    empties the result register
//  - a stalled receiver holds the result register; the next request is still taken
//    and worked on, then waits before the result register until it frees
`timescale 1ns / 1ps
`default_nettype none
module tap_tempo_estimator (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              req_type,
	input  wire logic [tte_pkg::TIME_W-1:0]        now_ms,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [tte_pkg::STATUS_W-1:0]           tap_status,
	output logic [tte_pkg::BPM_W-1:0]              bpm_milli,
	output logic [tte_pkg::COUNT_W-1:0]            tap_count,
	output logic [tte_pkg::RING_LOG2-1:0]          ring_position,
	input  wire logic                              cfg_we,
	input  wire logic [tte_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [tte_pkg::CFG_W-1:0]         cfg_data
);
	import tte_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_CMP  = 4'b0010,
		S_DIV  = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t                 state_q;
	logic [CFG_W-1:0]       debounce_q;
	logic [CFG_W-1:0]       timeout_q;
	logic [TIME_W-1:0]      last_q;
	logic [TIME_W-1:0]      now_q;
	logic [INTERVAL_W-1:0]  ring_q [RING_DEPTH];
	logic [SUM_W-1:0]       sum_q;
	logic [RING_LOG2-1:0]   idx_q;
	logic [COUNT_W-1:0]     cnt_q;
	logic [STATUS_W-1:0]    stat_q;
	logic [BPM_W-1:0]       bpm_q;

	logic                   out_valid_q;
	logic [STATUS_W-1:0]    out_status_q;
	logic [BPM_W-1:0]       out_bpm_q;
	logic [COUNT_W-1:0]     out_count_q;
	logic [RING_LOG2-1:0]   out_pos_q;

	logic                   accept;
	logic                   cmp_start;
	logic                   cmp_done;
	cmp_res_t               cmp_res;
	logic                   div_start;
	logic                   div_done;
	logic [BPM_W-1:0]       div_quot;
	logic [SUM_W-1:0]       sum_next;
	logic                   ring_full;
	logic                   store;
	logic                   out_load;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid & in_ready;
	assign cmp_start = accept & (req_type == REQ_TAP);

	// running sum: drop the interval being overwritten, add the new one
	assign sum_next  = sum_q - SUM_W'(ring_q[idx_q]) + SUM_W'(cmp_res.delay);
	assign ring_full = (cnt_q >= COUNT_W'(RING_DEPTH));
	assign store     = (state_q == S_CMP) & cmp_done & ~cmp_res.bounce & ~cmp_res.restart;
	assign div_start = store & ring_full;
	assign out_load  = (state_q == S_DONE) & (~out_valid_q | out_ready);

	tte_serial_cmp u_cmp (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmp_start),
		.now      (now_ms),
		.last     (last_q),
		.debounce (debounce_q),
		.timeout  (timeout_q),
		.done     (cmp_done),
		.res      (cmp_res)
	);

	tte_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (sum_next[SUM_W-1:RING_LOG2]),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
			timeout_q  <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEBOUNCE: debounce_q <= cfg_data;
				CFG_TIMEOUT:  timeout_q  <= cfg_data;
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			last_q  <= '0;
			sum_q   <= '0;
			idx_q   <= '0;
			cnt_q   <= '0;
			for (int i = 0; i < RING_DEPTH; i++)
				ring_q[i] <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req_type == REQ_CANCEL) begin
							last_q  <= '0;
							sum_q   <= '0;
							idx_q   <= '0;
							cnt_q   <= '0;
							for (int i = 0; i < RING_DEPTH; i++)
								ring_q[i] <= '0;
							state_q <= S_DONE;
						end else begin
							state_q <= S_CMP;
						end
					end
				end
				S_CMP: begin
					if (cmp_done) begin
						if (cmp_res.bounce) begin
							state_q <= S_DONE;
						end else if (cmp_res.restart) begin
							last_q  <= now_q;
							sum_q   <= '0;
							idx_q   <= '0;
							cnt_q   <= COUNT_W'(1);
							for (int i = 0; i < RING_DEPTH; i++)
								ring_q[i] <= '0;
							state_q <= S_DONE;
						end else begin
							last_q        <= now_q;
							ring_q[idx_q] <= cmp_res.delay;
							sum_q         <= sum_next;
							idx_q         <= idx_q + 1'b1;
							if (ring_full) begin
								cnt_q   <= COUNT_W'(RING_DEPTH + 1);
								state_q <= S_DIV;
							end else begin
								cnt_q   <= cnt_q + 1'b1;
								state_q <= S_DONE;
							end
						end
					end
				end
				S_DIV: begin
					if (div_done)
						state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// pending result of the request in flight
	always_ff @(posedge clk) begin
		if (accept) begin
			now_q  <= now_ms;
			stat_q <= ST_CANCEL;
			bpm_q  <= '0;
		end
		if ((state_q == S_CMP) && cmp_done) begin
			if (cmp_res.bounce)
				stat_q <= ST_BOUNCE;
			else if (cmp_res.restart)
				stat_q <= ST_RESTART;
			else
				stat_q <= ST_STORED;
		end
		if ((state_q == S_DIV) && div_done) begin
			stat_q <= ST_TEMPO;
			bpm_q  <= div_quot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= stat_q;
			out_bpm_q    <= bpm_q;
			out_count_q  <= cnt_q;
			out_pos_q    <= idx_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign tap_status    = out_status_q;
	assign bpm_milli     = out_bpm_q;
	assign tap_count     = out_count_q;
	assign ring_position = out_pos_q;

endmodule
`default_nettype wire

/* sv/tte_serial_cmp.sv */
// tte_serial_cmp: bit-serial interval subtractor with debounce and timeout compares,
// least significant bit first. Depends on tte_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tte_serial_cmp (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [tte_pkg::TIME_W-1:0]     now,
	input  wire logic [tte_pkg::TIME_W-1:0]     last,
	input  wire logic [tte_pkg::CFG_W-1:0]      debounce,
	input  wire logic [tte_pkg::CFG_W-1:0]      timeout,
	output logic                                done,
	output tte_pkg::cmp_res_t                   res
);
	import tte_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [CMP_CNT_W-1:0]  cnt_q;
	logic [TIME_W-1:0]     now_sr_q;
	logic [TIME_W-1:0]     last_sr_q;
	logic [CFG_W-1:0]      deb_sr_q;
	logic [CFG_W-1:0]      to_sr_q;
	logic                  borrow_q;
	logic                  lt_q;
	logic                  gt_q;
	logic                  nz_q;
	logic [INTERVAL_W-1:0] delay_q;
	cmp_res_t              res_q;

	logic now_b, last_b, deb_b, to_b;
	logic d, borrow_n, lt_n, gt_n, nz_n;
	logic last_bit;

	always_comb begin
		now_b    = now_sr_q[0];
		last_b   = last_sr_q[0];
		deb_b    = deb_sr_q[0];
		to_b     = to_sr_q[0];
		d        = now_b ^ last_b ^ borrow_q;
		borrow_n = (~now_b & last_b) | (~(now_b ^ last_b) & borrow_q);
		// higher bits decide, so a differing bit overrides what lower bits said
		lt_n     = (d ^ deb_b) ? deb_b : lt_q;
		gt_n     = (d ^ to_b) ? d : gt_q;
		nz_n     = nz_q | last_b;
		last_bit = (cnt_q == CMP_CNT_W'(TIME_W - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_bit) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			now_sr_q  <= now;
			last_sr_q <= last;
			deb_sr_q  <= debounce;
			to_sr_q   <= timeout;
			borrow_q  <= 1'b0;
			lt_q      <= 1'b0;
			gt_q      <= 1'b0;
			nz_q      <= 1'b0;
		end else if (busy_q) begin
			now_sr_q  <= {1'b0, now_sr_q[TIME_W-1:1]};
			last_sr_q <= {1'b0, last_sr_q[TIME_W-1:1]};
			deb_sr_q  <= {1'b0, deb_sr_q[CFG_W-1:1]};
			to_sr_q   <= {1'b0, to_sr_q[CFG_W-1:1]};
			borrow_q  <= borrow_n;
			lt_q      <= lt_n;
			gt_q      <= gt_n;
			nz_q      <= nz_n;
			if (cnt_q < CMP_CNT_W'(INTERVAL_W))
				delay_q <= {d, delay_q[INTERVAL_W-1:1]};
			if (last_bit) begin
				res_q.bounce  <= lt_n;
				res_q.restart <= ~nz_n | gt_n;
				res_q.delay   <= delay_q;
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule
`default_nettype wire

/* sv/tte_divider.sv */
// tte_divider: restoring divider of the tempo numerator by the mean interval,
// one quotient bit per cycle, saturating on a zero divisor. Depends on tte_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tte_divider (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [tte_pkg::INTERVAL_W-1:0]  divisor,
	output logic                                 done,
	output logic [tte_pkg::BPM_W-1:0]            quotient
);
	import tte_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [BPM_W-1:0]      num_sr_q;
	logic [BPM_W-1:0]      quot_q;
	logic [INTERVAL_W-1:0] rem_q;
	logic [INTERVAL_W-1:0] div_q;

	logic [INTERVAL_W:0]   trial;
	logic                  fits;
	logic [INTERVAL_W:0]   diff;
	logic                  last_step;

	always_comb begin
		trial     = {rem_q, num_sr_q[BPM_W-1]};
		fits      = (trial >= {1'b0, div_q});
		diff      = trial - {1'b0, div_q};
		last_step = (cnt_q == DIV_CNT_W'(BPM_W - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= '0;
				// zero mean saturates at once
				if (divisor == '0)
					done_q <= 1'b1;
				else
					busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_step) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_sr_q <= BPM_NUMERATOR;
			rem_q    <= '0;
			div_q    <= divisor;
			quot_q   <= (divisor == '0) ? BPM_NUMERATOR : '0;
		end else if (busy_q) begin
			num_sr_q <= {num_sr_q[BPM_W-2:0], 1'b0};
			rem_q    <= fits ? diff[INTERVAL_W-1:0] : trial[INTERVAL_W-1:0];
			quot_q   <= {quot_q[BPM_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule
`default_nettype wire

/* sv/tte_checker.sv */
// tte_checker: port-level assertions for the tap tempo estimator, bound to the top.
// Depends on tte_pkg and tap_tempo_estimator.
`timescale 1ns / 1ps
`default_nettype none
module tte_checker (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              out_valid,
	input  wire logic                              out_ready,
	input  wire logic [tte_pkg::STATUS_W-1:0]      tap_status,
	input  wire logic [tte_pkg::BPM_W-1:0]         bpm_milli,
	input  wire logic [tte_pkg::COUNT_W-1:0]       tap_count,
	input  wire logic [tte_pkg::RING_LOG2-1:0]     ring_position
);
	import tte_pkg::*;

	// a cancel leaves no tap state behind
	a_cancel_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (tap_status == ST_CANCEL) |->
			(tap_count == '0) && (ring_position == '0) && (bpm_milli == '0))
		else $error("cancel result carries tap state");

	// tempo is only reported with the count held past a full ring
	a_tempo_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (tap_status == ST_TEMPO) |-> (tap_count == COUNT_W'(RING_DEPTH + 1)))
		else $error("tempo reported before the ring is full");

	a_bpm_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (tap_status != ST_TEMPO) |-> (bpm_milli == '0))
		else $error("tempo field set without a tempo result");

	a_restart_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (tap_status == ST_RESTART) |->
			(tap_count == COUNT_W'(1)) && (ring_position == '0))
		else $error("restart does not begin a fresh sequence");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tap_status) && $stable(bpm_milli))
		else $error("result changed while stalled");

endmodule

bind tap_tempo_estimator tte_checker u_tte_checker (.*);
`default_nettype wire
